>>> sv/wam_pkg.sv
// Shared types, widths and codes of the weighted adjacency matrix table.
`default_nettype none
package wam_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 16;
  localparam int unsigned ACTION_W         = 2;
  localparam int unsigned VERTEX_W         = 4;
  localparam int unsigned WEIGHT_W         = 32;
  localparam int unsigned STATUS_W         = 2;
  localparam int unsigned NEIGHBOUR_W      = 4;
  localparam int unsigned EDGE_W           = 7;
  localparam int unsigned VCOUNT_W         = 5;

  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET   = VCOUNT_W'(16);
  // +infinity marks an absent edge
  localparam logic [WEIGHT_W-1:0] ABSENT_PATTERN = 32'h7F80_0000;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_LIST   = 2'd2,
    ACT_READ   = 2'd3
  } act_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_INVALID = 2'd1,
    STAT_NONE    = 2'd2
  } stat_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_WRITE_AB,
    S_WRITE_BA,
    S_RESP,
    S_SCAN,
    S_FINISH
  } state_e;

endpackage
`default_nettype wire

>>> sv/wam_in_if.sv
// Input channel: one action word with its vertices and weight.
`default_nettype none
interface wam_in_if;
  import wam_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [VERTEX_W-1:0] vertex_a;
  logic [VERTEX_W-1:0] vertex_b;
  logic [WEIGHT_W-1:0] edge_weight;

  modport source (output valid, action, vertex_a, vertex_b, edge_weight, input ready);
  modport sink   (input valid, action, vertex_a, vertex_b, edge_weight, output ready);
endinterface
`default_nettype wire

>>> sv/wam_out_if.sv
// Output channel: one result word per response or listed neighbour.
`default_nettype none
interface wam_out_if;
  import wam_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [STATUS_W-1:0]    status;
  logic [NEIGHBOUR_W-1:0] neighbour;
  logic [WEIGHT_W-1:0]    weight_out;
  logic [EDGE_W-1:0]      edges_now;
  logic                   last_result;

  modport source (output valid, status, neighbour, weight_out, edges_now, last_result,
                  input ready);
  modport sink   (input valid, status, neighbour, weight_out, edges_now, last_result,
                  output ready);
endinterface
`default_nettype wire

>>> sv/weighted_adjacency_matrix_table.sv
// Steps from accept to result: an error goes straight to the response; a read first
//   reads the memory; add/remove read, then write {a,b} and {b,a}, then respond. A
//   neighbour query reads one row entry per cycle while the result register has room.
// One word at a time; the weight memory is used as a single port (one access a cycle).
// Reset: control clears at once, then a clearing pass fills every memory entry with
//   +infinity; no word is taken until it ends.
`default_nettype none
module weighted_adjacency_matrix_table #(
  parameter int unsigned MAX_VERTICES = wam_pkg::MAX_VERTICES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          vertex_count_we_i,
  input  logic [wam_pkg::VCOUNT_W-1:0]  vertex_count_i,
  wam_in_if.sink                        in_i,
  wam_out_if.source                     out_o
);
  import wam_pkg::*;

  // Row and column index width, count width, memory address width
  localparam int unsigned IW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned NW0   = $clog2(MAX_VERTICES + 1);
  localparam int unsigned NW    = (NW0 > VCOUNT_W) ? NW0 : VCOUNT_W;
  localparam int unsigned AW    = 2 * IW;
  localparam int unsigned DEPTH = 1 << AW;

  state_e state_q, state_d;

  // Weight memory, row-major {row, column}
  logic [WEIGHT_W-1:0] mem [DEPTH];
  logic [WEIGHT_W-1:0] rdata_q;
  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  logic [WEIGHT_W-1:0] mem_wdata;

  logic [AW-1:0]       clr_idx_q;
  logic [VCOUNT_W-1:0] vcount_q;
  logic [EDGE_W-1:0]   cnt_q, cnt_d;

  // Latched item
  act_e                act_q;
  logic [IW-1:0]       a_q, b_q;
  logic [WEIGHT_W-1:0] w_q;
  logic                err_q;

  // Row scan: next column to issue, column in flight, pending neighbour
  logic [NW-1:0]       idx_q, rd_idx_q, hold_idx_q;
  logic                rd_vld_q, hold_vld_q;
  logic [WEIGHT_W-1:0] hold_w_q;

  // Result register
  logic                   out_vld_q;
  logic [STATUS_W-1:0]    out_status_q;
  logic [NEIGHBOUR_W-1:0] out_nb_q;
  logic [WEIGHT_W-1:0]    out_w_q;
  logic [EDGE_W-1:0]      out_cnt_q;
  logic                   out_last_q;

  logic [NW-1:0]       n_live, in_a_ext, in_b_ext;
  logic                in_acc, in_err, out_free;
  logic [WEIGHT_W-1:0] new_w;
  logic                present, scan_more, scan_consume, scan_stall, scan_issue, scan_take;
  logic                push;
  stat_e               push_status;
  logic [NEIGHBOUR_W-1:0] push_nb;
  logic [WEIGHT_W-1:0] push_w;
  logic                push_last;

  // Live vertex count, capped at the store size
  assign n_live   = (NW'(vcount_q) < NW'(MAX_VERTICES)) ? NW'(vcount_q) : NW'(MAX_VERTICES);
  assign in_a_ext = NW'(in_i.vertex_a);
  assign in_b_ext = NW'(in_i.vertex_b);
  assign in_acc   = in_i.valid && in_i.ready;

  // A query only needs vertex_b in range; the rest also reject self-loops
  always_comb begin
    if (act_e'(in_i.action) == ACT_LIST) begin
      in_err = (in_b_ext >= n_live);
    end else begin
      in_err = (in_a_ext >= n_live) || (in_b_ext >= n_live) || (in_a_ext == in_b_ext);
    end
  end

  assign out_free = !out_vld_q || out_o.ready;
  assign new_w    = (act_q == ACT_ADD) ? w_q : ABSENT_PATTERN;

  // Edge count moves only when presence changes
  always_comb begin
    cnt_d = cnt_q;
    if ((rdata_q == ABSENT_PATTERN) && (new_w != ABSENT_PATTERN)) begin
      cnt_d = cnt_q + 1'b1;
    end else if ((rdata_q != ABSENT_PATTERN) && (new_w == ABSENT_PATTERN)) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // Scan: a present entry displaces the pending neighbour into the result
  // register, so hold the entry (no new read) while that register is full.
  assign present      = (rdata_q != ABSENT_PATTERN);
  assign scan_more    = (idx_q < n_live);
  assign scan_consume = rd_vld_q && !(present && hold_vld_q && !out_free);
  assign scan_stall   = rd_vld_q && !scan_consume;
  assign scan_issue   = (state_q == S_SCAN) && !scan_stall && scan_more;
  assign scan_take    = (state_q == S_SCAN) && scan_consume && present;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (&clr_idx_q) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          if (in_err) begin
            state_d = S_RESP;
          end else if (act_e'(in_i.action) == ACT_LIST) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        state_d = (act_q == ACT_READ) ? S_RESP : S_WRITE_AB;
      end
      S_WRITE_AB: state_d = S_WRITE_BA;
      S_WRITE_BA: state_d = S_RESP;
      S_RESP: begin
        if (out_free) state_d = S_IDLE;
      end
      S_SCAN: begin
        if (!scan_stall && !scan_more) state_d = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State outputs: memory port, input ready, result push
  always_comb begin
    in_i.ready  = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = ABSENT_PATTERN;
    mem_re      = 1'b0;
    mem_raddr   = {a_q, b_q};
    push        = 1'b0;
    push_status = STAT_OK;
    push_nb     = '0;
    push_w      = '0;
    push_last   = 1'b1;
    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx_q;
      end
      S_IDLE: begin
        in_i.ready = 1'b1;
      end
      S_READ: begin
        mem_re = 1'b1;
      end
      S_WRITE_AB: begin
        mem_we    = 1'b1;
        mem_waddr = {a_q, b_q};
        mem_wdata = new_w;
      end
      S_WRITE_BA: begin
        mem_we    = 1'b1;
        mem_waddr = {b_q, a_q};
        mem_wdata = new_w;
      end
      S_RESP: begin
        push = out_free;
        if (err_q) begin
          push_status = STAT_INVALID;
        end else if (act_q == ACT_READ) begin
          push_w = rdata_q;
        end else begin
          push_w = new_w;
        end
      end
      S_SCAN: begin
        mem_re    = scan_issue;
        mem_raddr = {b_q, idx_q[IW-1:0]};
        // Release the previous neighbour, not the last
        push      = scan_take && hold_vld_q;
        push_nb   = hold_idx_q[NEIGHBOUR_W-1:0];
        push_w    = hold_w_q;
        push_last = 1'b0;
      end
      S_FINISH: begin
        push = out_free;
        if (hold_vld_q) begin
          push_nb = hold_idx_q[NEIGHBOUR_W-1:0];
          push_w  = hold_w_q;
        end else begin
          push_status = STAT_NONE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem[mem_raddr];
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_idx_q  <= '0;
      vcount_q   <= VCOUNT_RESET;
      cnt_q      <= '0;
      out_vld_q  <= 1'b0;
      hold_vld_q <= 1'b0;
      rd_vld_q   <= 1'b0;
      idx_q      <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_idx_q <= clr_idx_q + 1'b1;
      if (vertex_count_we_i) vcount_q <= vertex_count_i;
      if (state_q == S_WRITE_AB) cnt_q <= cnt_d;
      if (push) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if (in_acc) begin
        hold_vld_q <= 1'b0;
        rd_vld_q   <= 1'b0;
        idx_q      <= '0;
      end else if (state_q == S_SCAN) begin
        rd_vld_q <= scan_stall || scan_issue;
        if (scan_issue) idx_q <= idx_q + 1'b1;
        if (scan_take) hold_vld_q <= 1'b1;
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q <= act_e'(in_i.action);
      a_q   <= in_a_ext[IW-1:0];
      b_q   <= in_b_ext[IW-1:0];
      w_q   <= in_i.edge_weight;
      err_q <= in_err;
    end
    if (scan_issue) rd_idx_q <= idx_q;
    if (scan_take) begin
      hold_idx_q <= rd_idx_q;
      hold_w_q   <= rdata_q;
    end
    if (push) begin
      out_status_q <= push_status;
      out_nb_q     <= push_nb;
      out_w_q      <= push_w;
      out_cnt_q    <= cnt_q;
      out_last_q   <= push_last;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.status      = out_status_q;
  assign out_o.neighbour   = out_nb_q;
  assign out_o.weight_out  = out_w_q;
  // Capture the count with the word, as the next item may move it while this one waits
  assign out_o.edges_now   = out_cnt_q;
  assign out_o.last_result = out_last_q;

endmodule
`default_nettype wire

>>> sv/wam_checker.sv
// Port-level checks of the adjacency matrix table, bound to the top level.
`default_nettype none
module wam_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [wam_pkg::STATUS_W-1:0]    out_status_i,
  input  logic [wam_pkg::NEIGHBOUR_W-1:0] out_neighbour_i,
  input  logic [wam_pkg::WEIGHT_W-1:0]    out_weight_i,
  input  logic                          out_last_i
);
  import wam_pkg::*;

  // Stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_status_i)
      && $stable(out_weight_i) && $stable(out_last_i))
    else $error("stalled result word changed");

  // One word in flight: no accept right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while previous word busy");

  // Error and empty results close the item and carry no weight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i == STAT_INVALID || out_status_i == STAT_NONE)
      |-> out_last_i && out_weight_i == '0 && out_neighbour_i == '0)
    else $error("error or empty result malformed");

  // Only listed neighbours may be followed by further results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> out_status_i == STAT_OK)
    else $error("non-final result with bad status");

endmodule

bind weighted_adjacency_matrix_table wam_checker u_wam_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_status_i    (out_o.status),
  .out_neighbour_i (out_o.neighbour),
  .out_weight_i    (out_o.weight_out),
  .out_last_i      (out_o.last_result)
);
`default_nettype wire
